// ===== sv/pressure_temperature_compensation_core_assert.svh =====
// Assertion macros shared by the compensation core RTL.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ptc_pkg.sv =====
// Types and constants shared by the compensation core modules.
`default_nettype none
package ptc_pkg;

   localparam int OFF_W  = 40;
   localparam int SENS_W = 40;

   // Calibration register indexes.
   localparam logic [2:0] CSR_PRESSURE_SENSITIVITY   = 3'd0;
   localparam logic [2:0] CSR_PRESSURE_OFFSET        = 3'd1;
   localparam logic [2:0] CSR_SENSITIVITY_TEMP_SLOPE = 3'd2;
   localparam logic [2:0] CSR_OFFSET_TEMP_SLOPE      = 3'd3;
   localparam logic [2:0] CSR_REFERENCE_TEMPERATURE  = 3'd4;
   localparam logic [2:0] CSR_TEMPERATURE_SLOPE      = 3'd5;

   // 20.00 C base of the first-order temperature.
   localparam logic signed [18:0] TEMP_BASE = 19'sd2000;
   // Distance from 20.00 C down to -15.00 C.
   localparam logic signed [19:0] DEEP_COLD_SPAN = 20'sd3500;

   typedef struct packed {
      logic [15:0] pressure_sensitivity;
      logic [15:0] pressure_offset;
      logic [15:0] sensitivity_temp_slope;
      logic [15:0] offset_temp_slope;
      logic [15:0] reference_temperature;
      logic [15:0] temperature_slope;
   } cal_type;

   // First-order results handed to the correction stages.
   typedef struct packed {
      logic [23:0]              pressure_raw;
      logic signed [18:0]       temp;
      logic signed [18:0]       diff;       // temp - 2000
      logic signed [19:0]       cold_diff;  // temp + 1500
      logic                     cold;       // temp below 20 C
      logic                     deep;       // temp below -15 C
      logic [16:0]              ti;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
   } front_type;

   // Corrected terms handed to the pressure stages.
   typedef struct packed {
      logic [23:0]              pressure_raw;
      logic signed [18:0]       temp2;
      logic signed [SENS_W-1:0] sens_net;
      logic signed [OFF_W-1:0]  off_net;
   } corr_type;

   typedef struct packed {
      logic signed [31:0] pressure_decimbar;
      logic signed [18:0] temperature_centi;
   } result_type;

endpackage
`default_nettype wire

// ===== sv/ptc_front.sv =====
// First-order stages: dT, products, temperature, offset, sensitivity, Ti.
`default_nettype none
module ptc_front import ptc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cal_type     cal,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [23:0] pressure_raw,
   input  logic [23:0] temperature_raw,
   output logic        out_valid,
   input  logic        out_ready,
   output front_type   out_data
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];

   // Stage 0: dT.
   logic [23:0]        d1_s0_ff;
   logic signed [24:0] dt_in, dt_s0_ff;

   assign dt_in = $signed({1'b0, temperature_raw})
                - $signed({1'b0, cal.reference_temperature, 8'h00});

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d1_s0_ff <= pressure_raw;
         dt_s0_ff <= dt_in;
      end
   end

   // Stage 1: products of dT.
   logic [23:0]        d1_s1_ff;
   logic signed [41:0] pt_in, pt_s1_ff;
   logic signed [41:0] poff_in, poff_s1_ff;
   logic signed [41:0] psens_in, psens_s1_ff;
   logic signed [49:0] dtsq_full;
   logic [47:0]        dtsq_s1_ff;

   assign pt_in     = dt_s0_ff * $signed({1'b0, cal.temperature_slope});
   assign poff_in   = dt_s0_ff * $signed({1'b0, cal.offset_temp_slope});
   assign psens_in  = dt_s0_ff * $signed({1'b0, cal.sensitivity_temp_slope});
   assign dtsq_full = dt_s0_ff * dt_s0_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         d1_s1_ff    <= d1_s0_ff;
         pt_s1_ff    <= pt_in;
         poff_s1_ff  <= poff_in;
         psens_s1_ff <= psens_in;
         dtsq_s1_ff  <= dtsq_full[47:0];
      end
   end

   // Stage 2: scale with truncation toward zero, pick the Ti band.
   logic signed [41:0]       pt_adj, pt_q;
   logic signed [41:0]       poff_adj, poff_q;
   logic signed [41:0]       psens_adj, psens_q;
   logic signed [18:0]       q;
   logic signed [OFF_W-1:0]  poff_t;
   logic signed [SENS_W-1:0] psens_t;
   logic [49:0]              dtsq3;
   front_type                front_in, front_ff;

   assign pt_adj    = pt_s1_ff + (pt_s1_ff[41] ? 42'sd8388607 : 42'sd0);
   assign pt_q      = pt_adj >>> 23;
   assign q         = pt_q[18:0];
   assign poff_adj  = poff_s1_ff + (poff_s1_ff[41] ? 42'sd127 : 42'sd0);
   assign poff_q    = poff_adj >>> 7;
   assign poff_t    = poff_q[OFF_W-1:0];
   assign psens_adj = psens_s1_ff + (psens_s1_ff[41] ? 42'sd255 : 42'sd0);
   assign psens_q   = psens_adj >>> 8;
   assign psens_t   = psens_q[SENS_W-1:0];
   assign dtsq3     = {2'b00, dtsq_s1_ff} + {1'b0, dtsq_s1_ff, 1'b0};

   always_comb begin
      front_in.pressure_raw = d1_s1_ff;
      front_in.temp         = q + TEMP_BASE;
      front_in.diff         = q;
      front_in.cold_diff    = $signed({q[18], q}) + DEEP_COLD_SPAN;
      front_in.cold         = q[18];
      front_in.deep         = front_in.cold_diff[19];
      front_in.off          = $signed({8'h00, cal.pressure_offset, 16'h0000}) + poff_t;
      front_in.sens         = $signed({9'h000, cal.pressure_sensitivity, 15'h0000})
                            + psens_t;
      if (q[18]) begin
         front_in.ti = dtsq3[49:33];
      end else begin
         front_in.ti = {5'b00000, dtsq_s1_ff[47:36]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         front_ff <= front_in;
      end
   end

   assign out_data = front_ff;

endmodule
`default_nettype wire

// ===== sv/ptc_corr.sv =====
// Second-order correction stages: squares, OFFi and SENSi, net terms.
`default_nettype none
module ptc_corr import ptc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  front_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output corr_type  out_data
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];

   // Stage 0: squares and final temperature.
   logic signed [37:0]       sqa_full;
   logic signed [39:0]       sqb_full;
   logic [34:0]              sqa_s0_ff, sqb_s0_ff;
   logic signed [18:0]       temp2_in, temp2_s0_ff;
   logic [23:0]              d1_s0_ff;
   logic                     cold_s0_ff, deep_s0_ff;
   logic signed [OFF_W-1:0]  off_s0_ff;
   logic signed [SENS_W-1:0] sens_s0_ff;

   assign sqa_full = in_data.diff * in_data.diff;
   assign sqb_full = in_data.cold_diff * in_data.cold_diff;
   assign temp2_in = in_data.temp - $signed({2'b00, in_data.ti});

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sqa_s0_ff   <= sqa_full[34:0];
         sqb_s0_ff   <= sqb_full[34:0];
         temp2_s0_ff <= temp2_in;
         d1_s0_ff    <= in_data.pressure_raw;
         cold_s0_ff  <= in_data.cold;
         deep_s0_ff  <= in_data.deep;
         off_s0_ff   <= in_data.off;
         sens_s0_ff  <= in_data.sens;
      end
   end

   // Stage 1: OFFi and SENSi by band.
   logic [36:0]              tri_a;
   logic [37:0]              five_a, seven_b, four_b;
   logic [38:0]              offi_in, offi_s1_ff;
   logic [38:0]              sensi_in, sensi_s1_ff;
   logic [23:0]              d1_s1_ff;
   logic signed [18:0]       temp2_s1_ff;
   logic signed [OFF_W-1:0]  off_s1_ff;
   logic signed [SENS_W-1:0] sens_s1_ff;

   assign tri_a   = {2'b00, sqa_s0_ff} + {1'b0, sqa_s0_ff, 1'b0};
   assign five_a  = {3'b000, sqa_s0_ff} + {1'b0, sqa_s0_ff, 2'b00};
   assign seven_b = {sqb_s0_ff, 3'b000} - {3'b000, sqb_s0_ff};
   assign four_b  = {1'b0, sqb_s0_ff, 2'b00};

   always_comb begin
      if (cold_s0_ff) begin
         offi_in  = {3'b000, tri_a[36:1]}
                  + (deep_s0_ff ? {1'b0, seven_b} : 39'd0);
         sensi_in = {4'b0000, five_a[37:3]}
                  + (deep_s0_ff ? {1'b0, four_b} : 39'd0);
      end else begin
         offi_in  = {8'h00, sqa_s0_ff[34:4]};
         sensi_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         offi_s1_ff  <= offi_in;
         sensi_s1_ff <= sensi_in;
         d1_s1_ff    <= d1_s0_ff;
         temp2_s1_ff <= temp2_s0_ff;
         off_s1_ff   <= off_s0_ff;
         sens_s1_ff  <= sens_s0_ff;
      end
   end

   // Stage 2: net offset and sensitivity.
   corr_type corr_in, corr_ff;

   always_comb begin
      corr_in.pressure_raw = d1_s1_ff;
      corr_in.temp2        = temp2_s1_ff;
      corr_in.sens_net     = sens_s1_ff - $signed({1'b0, sensi_s1_ff});
      corr_in.off_net      = off_s1_ff - $signed({1'b0, offi_s1_ff});
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         corr_ff <= corr_in;
      end
   end

   assign out_data = corr_ff;

endmodule
`default_nettype wire

// ===== sv/ptc_press.sv =====
// Pressure stages: split multiply, scaling with truncation, saturation.
`default_nettype none
module ptc_press import ptc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  corr_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   localparam int STAGES = 5;
   localparam logic signed [43:0] PRES_MAX = 44'sd2147483647;
   localparam logic signed [43:0] PRES_MIN = -44'sd2147483648;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];

   // Stage 0: D1 times the low and high halves of the net sensitivity.
   logic [19:0]             sens_lo;
   logic signed [19:0]      sens_hi;
   logic [43:0]             plo_in, plo_s0_ff;
   logic signed [44:0]      phi_in, phi_s0_ff;
   logic signed [18:0]      temp2_s0_ff;
   logic signed [OFF_W-1:0] off_s0_ff;

   assign sens_lo = in_data.sens_net[19:0];
   assign sens_hi = in_data.sens_net[39:20];
   assign plo_in  = in_data.pressure_raw * sens_lo;
   assign phi_in  = $signed({1'b0, in_data.pressure_raw}) * sens_hi;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         plo_s0_ff   <= plo_in;
         phi_s0_ff   <= phi_in;
         temp2_s0_ff <= in_data.temp2;
         off_s0_ff   <= in_data.off_net;
      end
   end

   // Stage 1: combine partial products.
   logic signed [63:0]      prod_in, prod_s1_ff;
   logic signed [18:0]      temp2_s1_ff;
   logic signed [OFF_W-1:0] off_s1_ff;

   assign prod_in = (64'(phi_s0_ff) <<< 20) + $signed({20'h00000, plo_s0_ff});

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         prod_s1_ff  <= prod_in;
         temp2_s1_ff <= temp2_s0_ff;
         off_s1_ff   <= off_s0_ff;
      end
   end

   // Stage 2: divide by 2^21 toward zero.
   logic signed [63:0]      prod_adj, prod_q;
   logic signed [42:0]      a_s2_ff;
   logic signed [18:0]      temp2_s2_ff;
   logic signed [OFF_W-1:0] off_s2_ff;

   assign prod_adj = prod_s1_ff + (prod_s1_ff[63] ? 64'sd2097151 : 64'sd0);
   assign prod_q   = prod_adj >>> 21;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         a_s2_ff     <= prod_q[42:0];
         temp2_s2_ff <= temp2_s1_ff;
         off_s2_ff   <= off_s1_ff;
      end
   end

   // Stage 3: subtract the net offset.
   logic signed [43:0] b_in, b_s3_ff;
   logic signed [18:0] temp2_s3_ff;

   assign b_in = $signed({a_s2_ff[42], a_s2_ff})
               - $signed({{4{off_s2_ff[OFF_W-1]}}, off_s2_ff});

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         b_s3_ff     <= b_in;
         temp2_s3_ff <= temp2_s2_ff;
      end
   end

   // Stage 4: divide by 2^13 toward zero and clamp to 32 bits.
   logic signed [43:0] b_adj, pres_q;
   result_type         result_in, result_ff;

   assign b_adj  = b_s3_ff + (b_s3_ff[43] ? 44'sd8191 : 44'sd0);
   assign pres_q = b_adj >>> 13;

   always_comb begin
      result_in.temperature_centi = temp2_s3_ff;
      if (pres_q > PRES_MAX) begin
         result_in.pressure_decimbar = PRES_MAX[31:0];
      end else if (pres_q < PRES_MIN) begin
         result_in.pressure_decimbar = PRES_MIN[31:0];
      end else begin
         result_in.pressure_decimbar = pres_q[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         result_ff <= result_in;
      end
   end

   assign out_data = result_ff;

endmodule
`default_nettype wire

// ===== sv/pressure_temperature_compensation_core.sv =====
// An accepted req_ word passes the front, correction and pressure stages to rsp_tvalid.
// Throughput: one word per cycle unless rsp_ stalls; every stage holds a valid bit and
// moves on its own ready, so bubbles close up and a stalled rsp_ side backs up in order.
// The pressure product is a 24x40 multiply split in two 20-bit halves.
// Reset (synchronous) clears all six calibration words to zero and every
// pipeline valid bit; data registers are left as they are.
`default_nettype none
`include "pressure_temperature_compensation_core_assert.svh"
module pressure_temperature_compensation_core import ptc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [23:0] pressure_raw, [47:24] temperature_raw
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [18:0] temperature_centi, [50:19] pressure_decimbar, [55:51] zero
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cal_type cal_in, cal_ff;

   always_comb begin
      cal_in = cal_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PRESSURE_SENSITIVITY:   cal_in.pressure_sensitivity   = csr_wdata;
            CSR_PRESSURE_OFFSET:        cal_in.pressure_offset        = csr_wdata;
            CSR_SENSITIVITY_TEMP_SLOPE: cal_in.sensitivity_temp_slope = csr_wdata;
            CSR_OFFSET_TEMP_SLOPE:      cal_in.offset_temp_slope      = csr_wdata;
            CSR_REFERENCE_TEMPERATURE:  cal_in.reference_temperature  = csr_wdata;
            CSR_TEMPERATURE_SLOPE:      cal_in.temperature_slope      = csr_wdata;
            default: begin
               // drop writes past the last register
               cal_in = cal_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   logic       front_valid, front_ready;
   front_type  front_data;
   logic       corr_valid, corr_ready;
   corr_type   corr_data;
   result_type result;

   ptc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cal             (cal_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .pressure_raw    (req_tdata[23:0]),
      .temperature_raw (req_tdata[47:24]),
      .out_valid       (front_valid),
      .out_ready       (front_ready),
      .out_data        (front_data)
   );

   ptc_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (corr_valid),
      .out_ready (corr_ready),
      .out_data  (corr_data)
   );

   ptc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (corr_valid),
      .in_ready  (corr_ready),
      .in_data   (corr_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {5'b00000, result.pressure_decimbar, result.temperature_centi};

   `PTC_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid,
                    "pipeline not empty after reset")
   `PTC_ASSERT_SAME(a_stall_needs_full, clock, reset, !req_tready,
                    rsp_tvalid && !rsp_tready,
                    "input stalled while output side can move")
   `PTC_ASSERT_NEXT(a_csr_sens_write, clock, reset,
                    csr_we && csr_addr == CSR_PRESSURE_SENSITIVITY,
                    cal_ff.pressure_sensitivity == $past(csr_wdata),
                    "pressure sensitivity write lost")
   `PTC_ASSERT_NEXT(a_csr_hold, clock, reset, !csr_we, $stable(cal_ff),
                    "calibration changed without a write")

endmodule
`default_nettype wire
